// ----- rtl/mva_pkg.sv -----
// Shared constants, types and codes for the MIDI voice allocator.
package mva_pkg;

  localparam int unsigned VOICES      = 8;
  localparam int unsigned VoiceIdxW   = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 3;
  localparam int unsigned ActionW     = 3;
  localparam int unsigned OutIdxW     = 3;

  localparam int unsigned InFieldsW   = 3 * ByteW + LenW;
  localparam int unsigned InDataW     = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW  = ActionW + OutIdxW + 2 * ByteW;
  localparam int unsigned OutDataW    = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [3:0]      KindNoteOff = 4'h8;
  localparam logic [3:0]      KindNoteOn  = 4'h9;
  localparam logic [LenW-1:0] NoteLen     = LenW'(3);

  typedef enum logic [ActionW-1:0] {
    ActNone    = 3'd0,
    ActStart   = 3'd1,
    ActSteal   = 3'd2,
    ActRelease = 3'd3,
    ActNoMatch = 3'd4
  } action_e;

  typedef struct packed {
    logic            fire;
    logic            note_on;
    logic            note_off;
    logic [ByteW-1:0] key;
    logic [ByteW-1:0] vel;
  } mva_cmd_t;

  typedef struct packed {
    action_e           action;
    logic [OutIdxW-1:0] voice_index;
    logic [ByteW-1:0]   voice_key;
    logic [ByteW-1:0]   voice_velocity;
  } mva_result_t;

endpackage

// ----- rtl/mva_voice_bank.sv -----
// Voice state registers with first-free allocation, voice 0 steal when full, and key-match release.
module mva_voice_bank
  import mva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mva_cmd_t    cmd_i,
  output mva_result_t res_o
);

  logic [VOICES-1:0] gate_q, gate_d;
  logic [ByteW-1:0]  pitch_q [VOICES];
  logic [ByteW-1:0]  pitch_d [VOICES];
  logic [ByteW-1:0]  gain_q  [VOICES];
  logic [ByteW-1:0]  gain_d  [VOICES];

  logic                 free_found, match_found;
  logic [VoiceIdxW-1:0] free_idx, match_idx, res_idx;
  logic [VoiceIdxW+OutIdxW-1:0] idx_ext;

  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int unsigned v = 0; v < VOICES; v++) begin
      if (!free_found && !gate_q[v]) begin
        free_found = 1'b1;
        free_idx   = VoiceIdxW'(v);
      end
      if (!match_found && (pitch_q[v] == cmd_i.key)) begin
        match_found = 1'b1;
        match_idx   = VoiceIdxW'(v);
      end
    end
  end

  always_comb begin
    gate_d  = gate_q;
    pitch_d = pitch_q;
    gain_d  = gain_q;
    res_idx = '0;
    res_o   = '{action: ActNone, voice_index: '0, voice_key: '0, voice_velocity: '0};
    if (cmd_i.note_on) begin
      res_idx = free_found ? free_idx : '0;
      res_o.action         = free_found ? ActStart : ActSteal;
      res_o.voice_key      = cmd_i.key;
      res_o.voice_velocity = cmd_i.vel;
      gate_d[res_idx]  = 1'b1;
      pitch_d[res_idx] = cmd_i.key;
      gain_d[res_idx]  = cmd_i.vel;
    end else if (cmd_i.note_off) begin
      if (match_found) begin
        res_idx              = match_idx;
        res_o.action         = ActRelease;
        res_o.voice_key      = pitch_q[match_idx];
        res_o.voice_velocity = gain_q[match_idx];
        gate_d[match_idx]    = 1'b0;
      end else begin
        res_o.action = ActNoMatch;
      end
    end
    idx_ext           = {{OutIdxW{1'b0}}, res_idx};
    res_o.voice_index = idx_ext[OutIdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= '0;
      for (int unsigned v = 0; v < VOICES; v++) begin
        pitch_q[v] <= '0;
        gain_q[v]  <= '0;
      end
    end else if (cmd_i.fire) begin
      gate_q  <= gate_d;
      pitch_q <= pitch_d;
      gain_q  <= gain_d;
    end
  end

  a_gate_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.fire |=> $stable(gate_q))
    else $error("voice gates changed without a command");

  a_start_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && cmd_i.note_on && free_found |=>
      $countones(gate_q) == $past($countones(gate_q)) + 1)
    else $error("start did not set exactly one gate");

  a_steal_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && cmd_i.note_on && !free_found |=> gate_q == $past(gate_q))
    else $error("steal changed the gate set");

  a_release_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && cmd_i.note_off |=> $countones(gate_q) <= $past($countones(gate_q)))
    else $error("release raised a gate");

endmodule

// ----- rtl/midi_voice_allocator.sv -----
// Top level: one MIDI message per beat in, one allocation result per beat out.
// Path from input beat to output beat: input register, then result register.
// Throughput: one beat per cycle unless stalled; search and update are combinational.
// Voice state settles at the end of the cycle an item leaves the input register.
// Reset (rst_ni low, asynchronous) clears all gates, keys, velocities and valids.
module midi_voice_allocator
  import mva_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // status_byte[7:0], first_data_byte[15:8], second_data_byte[23:16],
  // message_length[26:24], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // action[2:0], voice_index[5:3], voice_key[13:6], voice_velocity[21:14], zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic                 in_valid_q, in_valid_d;
  logic [InDataW-1:0]   in_data_q;
  logic                 out_valid_q, out_valid_d;
  logic [OutDataW-1:0]  out_data_q;
  logic                 s_fire, s1_fire;

  logic [ByteW-1:0] status_byte, first_data_byte, second_data_byte;
  logic [LenW-1:0]  message_length;
  logic             len_ok;
  mva_cmd_t         cmd;
  mva_result_t      res;

  assign s1_fire         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || s1_fire;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign status_byte      = in_data_q[ByteW-1:0];
  assign first_data_byte  = in_data_q[2*ByteW-1:ByteW];
  assign second_data_byte = in_data_q[3*ByteW-1:2*ByteW];
  assign message_length   = in_data_q[3*ByteW+LenW-1:3*ByteW];
  assign len_ok           = (message_length == NoteLen);

  always_comb begin
    cmd.fire     = s1_fire;
    cmd.note_on  = len_ok && (status_byte[7:4] == KindNoteOn);
    cmd.note_off = len_ok && (status_byte[7:4] == KindNoteOff);
    cmd.key      = first_data_byte;
    cmd.vel      = second_data_byte;
  end

  mva_voice_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (s1_fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (s1_fire) begin
      out_data_q <= OutDataW'({res.voice_velocity, res.voice_key,
                               res.voice_index, res.action});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed beat not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !s1_fire)
    else $error("result register overwritten while stalled");

  a_input_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !s1_fire && !s_fire |=> in_valid_q && $stable(in_data_q))
    else $error("held input beat lost");

endmodule

// ----- dv/tb_midi_voice_allocator.sv -----
// Self-checking testbench for the MIDI voice allocator stream block.
`timescale 1ns / 100ps

module tb_midi_voice_allocator;
  import mva_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic              voice_gate_q [VOICES];
  logic [ByteW-1:0]  voice_key_q  [VOICES];
  logic [ByteW-1:0]  voice_vel_q  [VOICES];
  mva_result_t       alloc_q [$];
  mva_result_t       want;
  logic [ByteW-1:0]  key_pool [16];
  int                fail_count;
  int                src_idle_pct;
  int                dst_idle_pct;
  bit                stall_req;
  int                hold_left;

  midi_voice_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic mva_result_t allocate_voice(input logic [ByteW-1:0] status,
                                                 input logic [ByteW-1:0] key,
                                                 input logic [ByteW-1:0] vel,
                                                 input logic [LenW-1:0]  len);
    mva_result_t res;
    logic [3:0]  kind;
    bit          found;
    res   = '{action: ActNone, default: '0};
    kind  = status[7:4];
    found = 1'b0;
    if (len != NoteLen || (kind != KindNoteOn && kind != KindNoteOff)) return res;
    if (kind == KindNoteOn) begin
      for (int v = 0; v < VOICES; v++) begin
        if (!found && !voice_gate_q[v]) begin
          found           = 1'b1;
          voice_gate_q[v] = 1'b1;
          voice_key_q[v]  = key;
          voice_vel_q[v]  = vel;
          res = '{action: ActStart, voice_index: OutIdxW'(v), voice_key: key,
                  voice_velocity: vel};
        end
      end
      if (!found) begin
        voice_gate_q[0] = 1'b1;
        voice_key_q[0]  = key;
        voice_vel_q[0]  = vel;
        res = '{action: ActSteal, voice_index: '0, voice_key: key, voice_velocity: vel};
      end
    end else begin
      res.action = ActNoMatch;
      for (int v = 0; v < VOICES; v++) begin
        if (!found && voice_key_q[v] == key) begin
          found           = 1'b1;
          voice_gate_q[v] = 1'b0;
          res = '{action: ActRelease, voice_index: OutIdxW'(v), voice_key: voice_key_q[v],
                  voice_velocity: voice_vel_q[v]};
        end
      end
    end
    return res;
  endfunction

  // Hold valid across back-to-back beats; drop it only for an idle cycle.
  task automatic send_msg(input logic [ByteW-1:0] status, input logic [ByteW-1:0] key,
                          input logic [ByteW-1:0] vel, input logic [LenW-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({len, vel, key, status});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    alloc_q.push_back(allocate_voice(status, key, vel, len));
    @(negedge clk_i);
  endtask

  task automatic send_random_msg();
    logic [3:0] chan;
    chan = 4'($urandom_range(15));
    if ($urandom_range(99) < 75) begin
      send_msg({($urandom_range(1) != 0) ? KindNoteOn : KindNoteOff, chan},
               ($urandom_range(9) == 0) ? 8'($urandom) : key_pool[$urandom_range(15)],
               8'($urandom), NoteLen);
    end else begin
      send_msg(8'($urandom), 8'($urandom), 8'($urandom), LenW'($urandom_range(7)));
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_req) begin
      hold_left = 150;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (alloc_q.size() == 0) begin
        $error("result beat with no expected result: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = alloc_q.pop_front();
        if (m_axis_tdata[2:0] !== want.action) begin
          $error("action mismatch: expected %0d, got %0d", want.action, m_axis_tdata[2:0]);
          fail_count++;
        end
        if (m_axis_tdata[5:3] !== want.voice_index) begin
          $error("voice_index mismatch: expected %0d, got %0d", want.voice_index,
                 m_axis_tdata[5:3]);
          fail_count++;
        end
        if (m_axis_tdata[13:6] !== want.voice_key) begin
          $error("voice_key mismatch: expected %0d, got %0d", want.voice_key,
                 m_axis_tdata[13:6]);
          fail_count++;
        end
        if (m_axis_tdata[21:14] !== want.voice_velocity) begin
          $error("voice_velocity mismatch: expected %0d, got %0d", want.voice_velocity,
                 m_axis_tdata[21:14]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_msg(8'h80, 8'd0, 8'd9, NoteLen);
    send_msg(8'h90, 8'd0, 8'd0, NoteLen);
    send_msg(8'h9F, 8'd255, 8'd255, NoteLen);
    send_msg(8'h95, 8'd1, 8'd127, NoteLen);
    send_msg(8'h90, 8'd2, 8'd1, NoteLen);
    send_msg(8'h91, 8'd4, 8'd64, NoteLen);
    send_msg(8'h92, 8'd8, 8'd100, NoteLen);
    send_msg(8'h93, 8'd16, 8'd2, NoteLen);
    send_msg(8'h94, 8'd32, 8'd3, NoteLen);
    send_msg(8'h9A, 8'd128, 8'd127, NoteLen);
    send_msg(8'h8F, 8'd255, 8'd255, NoteLen);
    send_msg(8'h80, 8'd77, 8'd0, NoteLen);
    send_msg(8'h83, 8'd0, 8'd40, NoteLen);
    send_msg(8'h90, 8'd60, 8'd90, LenW'(0));
    send_msg(8'h90, 8'd60, 8'd90, LenW'(1));
    send_msg(8'h90, 8'd60, 8'd90, LenW'(2));
    send_msg(8'h80, 8'd128, 8'd90, LenW'(7));
    send_msg(8'hE0, 8'd128, 8'd0, NoteLen);
    send_msg(8'hB0, 8'd7, 8'd100, NoteLen);
    send_msg(8'hFF, 8'd255, 8'd255, LenW'(7));
    send_msg(8'h00, 8'd0, 8'd0, LenW'(2));
    send_msg(8'h70, 8'd32, 8'd0, NoteLen);
    send_msg(8'hA0, 8'd32, 8'd0, NoteLen);
  endtask

  task automatic test_random_mix(input int src_pct, input int dst_pct, input int count);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    repeat (count) send_random_msg();
  endtask

  task automatic test_backpressure();
    stall_req = 1'b1;
    repeat (40) send_random_msg();
  endtask

  initial begin
    int waited;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    src_idle_pct  = 12;
    dst_idle_pct  = 45;
    stall_req     = 1'b0;
    hold_left     = 0;
    for (int v = 0; v < VOICES; v++) begin
      voice_gate_q[v] = 1'b0;
      voice_key_q[v]  = '0;
      voice_vel_q[v]  = '0;
    end
    foreach (key_pool[i]) key_pool[i] = 8'($urandom);
    key_pool[0] = 8'd0;
    key_pool[1] = 8'd255;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_mix(12, 45, 520);
    test_backpressure();
    test_random_mix(45, 12, 520);
    test_random_mix(0, 0, 520);
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (alloc_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (alloc_q.size() != 0) begin
      $error("%0d expected results never arrived", alloc_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- midi_voice_allocator.f -----
rtl/mva_pkg.sv
rtl/mva_voice_bank.sv
rtl/midi_voice_allocator.sv
dv/tb_midi_voice_allocator.sv
